// ===== hdl/char_lcd_request_formatter_core_assert.svh =====
// Assertion macros shared by the LCD request formatter RTL.
`ifndef CHAR_LCD_REQUEST_FORMATTER_CORE_ASSERT_SVH
`define CHAR_LCD_REQUEST_FORMATTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CLF_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");
`define CLF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) ((ante) |=> (cons))) \
      else $error("%m: check failed");
`else
`define CLF_ASSERT(name, clk, rst, prop)
`define CLF_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/clfmt_pkg.sv =====
// Types and constants of the character LCD request formatter.
`default_nettype none
package clfmt_pkg;

   localparam logic [2:0] REQ_COMMAND  = 3'd0;
   localparam logic [2:0] REQ_CHAR     = 3'd1;
   localparam logic [2:0] REQ_NUMBER   = 3'd2;
   localparam logic [2:0] REQ_SET_POS  = 3'd3;
   localparam logic [2:0] REQ_PATTERN  = 3'd4;
   localparam logic [2:0] REQ_INIT     = 3'd5;

   localparam logic [1:0] REG_INIT_FUNCTION_SET = 2'd0;
   localparam logic [1:0] REG_INIT_DISPLAY_ON   = 2'd1;
   localparam logic [1:0] REG_INIT_CLEAR        = 2'd2;

   localparam logic [7:0] INIT_FUNCTION_SET_RST = 8'd56;
   localparam logic [7:0] INIT_DISPLAY_ON_RST   = 8'd12;
   localparam logic [7:0] INIT_CLEAR_RST        = 8'd1;

   localparam int         MAX_WRITES   = 9;
   localparam int         BYTES_W      = 8 * MAX_WRITES;
   localparam logic [3:0] COUNT_MAX    = 4'(MAX_WRITES);

   localparam logic [7:0]  SET_DDRAM   = 8'h80;
   localparam logic [7:0]  ROW1_OFFSET = 8'h40;
   localparam logic [7:0]  SET_CGRAM   = 8'h40;
   localparam logic [7:0]  ASCII_ZERO  = 8'h30;
   localparam logic [16:0] DIV10_MULT  = 17'd52429;

   typedef struct packed {
      logic               rs_first;
      logic               rs_rest;
      logic [3:0]         count;
      logic [BYTES_W-1:0] bytes;
   } clfmt_cmd_type;

endpackage
`default_nettype wire

// ===== hdl/clfmt_front.sv =====
// Front end: accepts requests, holds init registers, builds write bursts.
`default_nettype none
`include "char_lcd_request_formatter_core_assert.svh"
module clfmt_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [95:0]             req_tdata,
   input  wire logic [2:0]              req_tuser,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_index,
   input  wire logic [7:0]              csr_data,
   output logic                         q_push,
   output clfmt_pkg::clfmt_cmd_type     q_push_data,
   input  wire logic                    q_full
);
   import clfmt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CONV = 2'd1;
   localparam logic [1:0] S_PUSH = 2'd2;

   logic [1:0]    state_ff, state_in;
   clfmt_cmd_type cmd_ff, cmd_in;
   logic [15:0]   x_ff, x_in;
   logic [2:0]    pos_ff, pos_in;
   logic [7:0]    fset_ff, don_ff, clr_ff;

   logic [15:0]   value;
   logic [1:0]    row;
   logic [5:0]    col;
   logic [3:0]    slot;
   logic [63:0]   pattern;

   clfmt_cmd_type dec_cmd;
   logic [2:0]    dec_pos;
   logic          dec_number;

   logic [32:0]   prod;
   logic [12:0]   quot;
   logic [15:0]   rem;
   logic [7:0]    digit;

   assign value   = req_tdata[15:0];
   assign row     = req_tdata[17:16];
   assign col     = req_tdata[23:18];
   assign slot    = req_tdata[27:24];
   assign pattern = req_tdata[91:28];

   assign req_tready  = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign q_push_data = cmd_ff;

   always_comb begin
      dec_cmd    = '0;
      dec_pos    = 3'd0;
      dec_number = 1'b0;
      unique case (req_tuser)
         REQ_COMMAND: begin
            dec_cmd.count       = 4'd1;
            dec_cmd.bytes[7:0]  = value[7:0];
         end
         REQ_CHAR: begin
            dec_cmd.rs_first    = 1'b1;
            dec_cmd.count       = 4'd1;
            dec_cmd.bytes[7:0]  = value[7:0];
         end
         REQ_NUMBER: begin
            dec_number          = 1'b1;
            dec_cmd.rs_first    = 1'b1;
            dec_cmd.rs_rest     = 1'b1;
            if (value >= 16'd10000) begin
               dec_pos = 3'd4;
            end else if (value >= 16'd1000) begin
               dec_pos = 3'd3;
            end else if (value >= 16'd100) begin
               dec_pos = 3'd2;
            end else if (value >= 16'd10) begin
               dec_pos = 3'd1;
            end else begin
               dec_pos = 3'd0;
            end
            dec_cmd.count       = {1'b0, dec_pos} + 4'd1;
         end
         REQ_SET_POS: begin
            if (row == 2'd0) begin
               dec_cmd.count      = 4'd1;
               dec_cmd.bytes[7:0] = SET_DDRAM | {2'b00, col};
            end else if (row == 2'd1) begin
               dec_cmd.count      = 4'd1;
               dec_cmd.bytes[7:0] = SET_DDRAM | ROW1_OFFSET | {2'b00, col};
            end
         end
         REQ_PATTERN: begin
            if (!slot[3]) begin
               dec_cmd.rs_rest = 1'b1;
               dec_cmd.count   = COUNT_MAX;
               dec_cmd.bytes   = {pattern, SET_CGRAM | {2'b00, slot[2:0], 3'b000}};
            end
         end
         REQ_INIT: begin
            dec_cmd.count       = 4'd3;
            dec_cmd.bytes[23:0] = {clr_ff, don_ff, fset_ff};
         end
         default: begin
            dec_cmd = '0;
         end
      endcase
   end

   // one decimal digit per cycle: x/10 by reciprocal multiply, exact for 16 bits
   assign prod  = {16'd0, DIV10_MULT} * {17'd0, x_ff};
   assign quot  = prod[31:19];
   assign rem   = x_ff - ({quot, 3'b000} + {2'b00, quot, 1'b0});
   assign digit = ASCII_ZERO | {4'd0, rem[3:0]};

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      x_in     = x_ff;
      pos_in   = pos_ff;
      q_push   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = dec_cmd;
               x_in   = value;
               pos_in = dec_pos;
               if (dec_cmd.count == 4'd0) begin
                  state_in = S_IDLE;
               end else if (dec_number) begin
                  state_in = S_CONV;
               end else begin
                  state_in = S_PUSH;
               end
            end
         end
         S_CONV: begin
            cmd_in.bytes[{pos_ff, 3'b000} +: 8] = digit;
            x_in = {3'b000, quot};
            if (pos_ff == 3'd0) begin
               state_in = S_PUSH;
            end else begin
               pos_in = pos_ff - 3'd1;
            end
         end
         S_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fset_ff  <= INIT_FUNCTION_SET_RST;
         don_ff   <= INIT_DISPLAY_ON_RST;
         clr_ff   <= INIT_CLEAR_RST;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_INIT_FUNCTION_SET: fset_ff <= csr_data;
               REG_INIT_DISPLAY_ON:   don_ff  <= csr_data;
               REG_INIT_CLEAR:        clr_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      x_ff   <= x_in;
      pos_ff <= pos_in;
   end

   `CLF_ASSERT(a_push_count, clock, reset, q_push |-> (cmd_ff.count != 4'd0 && cmd_ff.count <= COUNT_MAX))
   `CLF_ASSERT(a_last_digit, clock, reset, (state_ff == S_CONV && pos_ff == 3'd0) |-> (x_ff < 16'd10))
   `CLF_ASSERT(a_pos_range, clock, reset, (state_ff == S_CONV) |-> (pos_ff <= 3'd4))
   `CLF_ASSERT_NEXT(a_conv_done, clock, reset, state_ff == S_CONV && pos_ff == 3'd0, state_ff == S_PUSH)

endmodule
`default_nettype wire

// ===== hdl/clfmt_queue.sv =====
// Small command queue between the front end and the bus write sequencer.
`default_nettype none
`include "char_lcd_request_formatter_core_assert.svh"
module clfmt_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire clfmt_pkg::clfmt_cmd_type push_data,
   output logic                         full,
   input  wire logic                    pop,
   output clfmt_pkg::clfmt_cmd_type     pop_data,
   output logic                         not_empty
);
   import clfmt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);

   clfmt_cmd_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CLF_ASSERT(a_count_range, clock, reset, count_ff <= FULL_COUNT)
   `CLF_ASSERT(a_no_overflow, clock, reset, push |-> (count_ff != FULL_COUNT))
   `CLF_ASSERT(a_no_underflow, clock, reset, pop |-> (count_ff != '0))

endmodule
`default_nettype wire

// ===== hdl/clfmt_back.sv =====
// Back end: plays queued bursts out as one bus write per beat.
`default_nettype none
module clfmt_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   input  wire clfmt_pkg::clfmt_cmd_type q_data,
   output logic                         q_pop,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [7:0]                   rsp_tdata,
   output logic [0:0]                   rsp_tuser,
   output logic                         rsp_tlast
);
   import clfmt_pkg::*;

   logic               active_ff;
   logic [BYTES_W-1:0] sh_ff;
   logic [3:0]         remain_ff;
   logic               rs_cur_ff, rs_rest_ff;
   logic               out_valid_ff;
   logic [7:0]         out_byte_ff;
   logic               out_rs_ff, out_last_ff;

   logic load_out, fire, finishing;

   assign load_out  = !out_valid_ff || rsp_tready;
   assign fire      = active_ff && load_out;
   assign finishing = fire && (remain_ff == 4'd1);
   assign q_pop     = q_valid && (!active_ff || finishing);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_rs_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (load_out) begin
            out_valid_ff <= 1'b0;
         end
         if (q_pop) begin
            active_ff <= 1'b1;
         end else if (finishing) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff <= sh_ff[7:0];
         out_rs_ff   <= rs_cur_ff;
         out_last_ff <= (remain_ff == 4'd1);
      end
      if (q_pop) begin
         sh_ff      <= q_data.bytes;
         remain_ff  <= q_data.count;
         rs_cur_ff  <= q_data.rs_first;
         rs_rest_ff <= q_data.rs_rest;
      end else if (fire) begin
         sh_ff      <= {8'd0, sh_ff[BYTES_W-1:8]};
         remain_ff  <= remain_ff - 4'd1;
         rs_cur_ff  <= rs_rest_ff;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/char_lcd_request_formatter_core.sv =====
// Character LCD request formatter: top level.
//
// Requests enter on the req_ stream (kind in req_tuser) and come out as
// LCD bus writes on the rsp_ stream, one write per beat: rsp_tdata is the
// bus byte, rsp_tuser the register-select bit, rsp_tlast marks the final
// write of a request. Requests that cause no write produce no beat.
// csr_ writes the three init command bytes; it is always ready.
// The front end takes a request only once the last is queued (numbers
// first convert their digits), hands a complete burst to a command
// queue of QUEUE_DEPTH entries, and the back end sends one write per
// cycle while rsp_tready is high, bursts back to back, so the write
// sequencer paces pattern saves. When rsp_tready is low the output
// register holds its beat, the queue fills, and then req_tready drops.
// Reset empties the queue, drops any burst in flight and restores the
// init command defaults.
`default_nettype none
module char_lcd_request_formatter_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // value, row, col, slot, pattern, zero fill
   input  wire logic [2:0]  req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // bus_byte
   output logic [0:0]       rsp_tuser,   // rs
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   import clfmt_pkg::*;

   logic          q_push, q_full, q_pop, q_valid;
   clfmt_cmd_type q_push_data, q_pop_data;

   clfmt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_push      (q_push),
      .q_push_data (q_push_data),
      .q_full      (q_full)
   );

   clfmt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_valid)
   );

   clfmt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== bench/char_lcd_request_formatter_write_monitor.sv =====
// Monitor for the LCD request formatter: predicts the bus writes of each request and checks them.
module char_lcd_request_formatter_write_monitor
   import clfmt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          writes_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       rs;
      logic [7:0] bus_byte;
      logic       last;
   } lcd_write_type;

   lcd_write_type writes_due_q[$];
   logic [7:0] cmd_function_set = INIT_FUNCTION_SET_RST;
   logic [7:0] cmd_display_on   = INIT_DISPLAY_ON_RST;
   logic [7:0] cmd_clear        = INIT_CLEAR_RST;
   int         fails = 0;

   // Appends the writes one request causes; the final one carries last.
   task automatic expand_request(input logic [2:0] kind, input logic [91:0] f);
      logic [15:0]   value;
      logic [1:0]    row;
      logic [5:0]    col;
      logic [3:0]    slot;
      logic [63:0]   pattern;
      int            digits[5];
      int            nd;
      int            x;
      int            size_before;
      lcd_write_type tail;
      value = f[15:0];
      row = f[17:16];
      col = f[23:18];
      slot = f[27:24];
      pattern = f[91:28];
      size_before = writes_due_q.size();
      case (kind)
         REQ_COMMAND: writes_due_q.push_back({1'b0, value[7:0], 1'b0});
         REQ_CHAR: writes_due_q.push_back({1'b1, value[7:0], 1'b0});
         REQ_NUMBER: begin
            x = value;
            nd = 0;
            do begin
               digits[nd] = x % 10;
               x = x / 10;
               nd++;
            end while (x != 0);
            for (int i = nd - 1; i >= 0; i--)
               writes_due_q.push_back({1'b1, ASCII_ZERO + 8'(digits[i]), 1'b0});
         end
         REQ_SET_POS: begin
            if (row == 2'd0)
               writes_due_q.push_back({1'b0, 8'h80 + {2'b00, col}, 1'b0});
            else if (row == 2'd1)
               writes_due_q.push_back({1'b0, 8'hC0 + {2'b00, col}, 1'b0});
         end
         REQ_PATTERN: begin
            if (slot < 4'd8) begin
               writes_due_q.push_back({1'b0, 8'h40 | {2'b00, slot[2:0], 3'b000}, 1'b0});
               for (int i = 0; i < 8; i++)
                  writes_due_q.push_back({1'b1, pattern[8*i +: 8], 1'b0});
            end
         end
         REQ_INIT: begin
            writes_due_q.push_back({1'b0, cmd_function_set, 1'b0});
            writes_due_q.push_back({1'b0, cmd_display_on, 1'b0});
            writes_due_q.push_back({1'b0, cmd_clear, 1'b0});
         end
         default: ;
      endcase
      if (writes_due_q.size() > size_before) begin
         tail = writes_due_q.pop_back();
         tail.last = 1'b1;
         writes_due_q.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      lcd_write_type want;
      if (reset) begin
         writes_due_q.delete();
         cmd_function_set = INIT_FUNCTION_SET_RST;
         cmd_display_on = INIT_DISPLAY_ON_RST;
         cmd_clear = INIT_CLEAR_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_INIT_FUNCTION_SET: cmd_function_set = csr_data;
               REG_INIT_DISPLAY_ON: cmd_display_on = csr_data;
               REG_INIT_CLEAR: cmd_clear = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expand_request(req_tuser, req_tdata[91:0]);
         if (rsp_tvalid && rsp_tready) begin
            if (writes_due_q.size() == 0) begin
               fails++;
               $display("%0t: unexpected beat rs=%0b byte=%02h last=%0b, nothing pending",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
            end else begin
               want = writes_due_q.pop_front();
               if (rsp_tuser !== want.rs || rsp_tdata !== want.bus_byte
                   || rsp_tlast !== want.last) begin
                  fails++;
                  $display("%0t: expected rs=%0b byte=%02h last=%0b, got rs=%0b byte=%02h last=%0b",
                           $time, want.rs, want.bus_byte, want.last,
                           rsp_tuser, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
      fail_count <= fails;
      writes_outstanding <= writes_due_q.size();
   end

endmodule

// ===== bench/char_lcd_request_formatter_core_tb.sv =====
// Testbench top for the LCD request formatter: drives requests and init settings, gives the verdict.
module char_lcd_request_formatter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import clfmt_pkg::*;

   localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;
   int          fail_count;
   int          writes_outstanding;

   int          req_calm = 0;
   int          rsp_calm = 0;
   int          sent_by_kind[8];
   int          beats_seen = 0;
   int          settings_used = 1;

   char_lcd_request_formatter_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   char_lcd_request_formatter_write_monitor write_monitor (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .writes_outstanding(writes_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

   // Idle cycles before the next beat; now and then a run with no idling.
   function automatic int next_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   task automatic send_request(input logic [2:0] kind, input logic [15:0] value,
                               input logic [1:0] row, input logic [5:0] col,
                               input logic [3:0] slot, input logic [63:0] pattern);
      int gap;
      gap = next_wait(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0000, pattern, slot, col, row, value};
      do @(posedge clock); while (!req_tready);
      sent_by_kind[kind]++;
   endtask

   // Waits for every predicted write, then lets in-flight empty requests drain.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (writes_outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_init_bytes(input logic [7:0] fs, input logic [7:0] don,
                                   input logic [7:0] clr);
      logic [1:0] reg_ids[3];
      logic [7:0] reg_vals[3];
      reg_ids = '{REG_INIT_FUNCTION_SET, REG_INIT_DISPLAY_ON, REG_INIT_CLEAR};
      reg_vals = '{fs, don, clr};
      csr_valid <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         csr_index <= reg_ids[i];
         csr_data <= reg_vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_requests(input int count);
      int          done;
      int          pick;
      logic [2:0]  kind;
      logic [15:0] value;
      logic [3:0]  slot;
      done = 0;
      send_request(REQ_INIT, 16'($urandom), 2'($urandom), 6'($urandom),
                   4'($urandom), {$urandom, $urandom});
      while (done < count) begin
         pick = $urandom_range(0, 19);
         if (pick < 3) kind = REQ_COMMAND;
         else if (pick < 6) kind = REQ_CHAR;
         else if (pick < 10) kind = REQ_NUMBER;
         else if (pick < 13) kind = REQ_SET_POS;
         else if (pick < 16) kind = REQ_PATTERN;
         else if (pick < 18) kind = REQ_INIT;
         else kind = pick[0] ? REQ_UNUSED_HI : REQ_UNUSED_LO;
         value = 16'($urandom);
         if (kind == REQ_NUMBER) begin
            case ($urandom_range(0, 4))
               0: value = 16'($urandom_range(0, 9));
               1: value = 16'($urandom_range(0, 99));
               2: value = 16'($urandom_range(0, 999));
               3: value = 16'($urandom_range(0, 9999));
               default: ;
            endcase
         end
         slot = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15))
                                            : 4'($urandom_range(0, 7));
         send_request(kind, value, 2'($urandom), 6'($urandom), slot, {$urandom, $urandom});
         if (kind != REQ_UNUSED_LO && kind != REQ_UNUSED_HI) done++;
      end
      settle();
   endtask

   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         stall = next_wait(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (!reset) beats_seen++;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_COMMAND;
      csr_valid = 1'b0;
      csr_index = REG_INIT_FUNCTION_SET;
      csr_data = '0;
      foreach (sent_by_kind[i]) sent_by_kind[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every request kind, rows and slots that do nothing
      send_request(REQ_COMMAND, 16'hFF00, 2'd0, 6'd0, 4'd0, 64'd0);
      send_request(REQ_COMMAND, 16'h00FF, 2'd3, 6'd63, 4'd15, '1);
      send_request(REQ_CHAR, 16'h0000, 2'd0, 6'd0, 4'd0, 64'd0);
      send_request(REQ_CHAR, 16'hFFFF, 2'd3, 6'd63, 4'd15, '1);
      send_request(REQ_NUMBER, 16'd0, 2'd0, 6'd0, 4'd0, 64'd0);
      send_request(REQ_NUMBER, 16'd9, 2'd0, 6'd0, 4'd0, 64'd0);
      send_request(REQ_NUMBER, 16'd10, 2'd0, 6'd0, 4'd0, 64'd0);
      send_request(REQ_NUMBER, 16'd100, 2'd0, 6'd0, 4'd0, 64'd0);
      send_request(REQ_NUMBER, 16'd12345, 2'd0, 6'd0, 4'd0, 64'd0);
      send_request(REQ_NUMBER, 16'd10000, 2'd0, 6'd0, 4'd0, 64'd0);
      send_request(REQ_NUMBER, 16'd65535, 2'd3, 6'd63, 4'd15, '1);
      send_request(REQ_SET_POS, 16'hFFFF, 2'd0, 6'd0, 4'd15, '1);
      send_request(REQ_SET_POS, 16'h0000, 2'd1, 6'd63, 4'd0, 64'd0);
      send_request(REQ_SET_POS, 16'h1234, 2'd2, 6'd21, 4'd3, 64'd0);
      send_request(REQ_SET_POS, 16'h0000, 2'd3, 6'd63, 4'd0, 64'd0);
      send_request(REQ_PATTERN, 16'h0000, 2'd0, 6'd0, 4'd0, '1);
      send_request(REQ_PATTERN, 16'hFFFF, 2'd3, 6'd63, 4'd7, 64'h0123456789ABCDEF);
      send_request(REQ_PATTERN, 16'h0000, 2'd0, 6'd0, 4'd8, 64'hFEDCBA9876543210);
      send_request(REQ_PATTERN, 16'h0000, 2'd1, 6'd5, 4'd15, 64'd0);
      send_request(REQ_INIT, 16'h0000, 2'd0, 6'd0, 4'd0, 64'd0);
      send_request(REQ_UNUSED_LO, 16'hFFFF, 2'd3, 6'd63, 4'd15, '1);
      send_request(REQ_UNUSED_HI, 16'hFFFF, 2'd0, 6'd0, 4'd0, '1);
      send_request(REQ_INIT, 16'hFFFF, 2'd3, 6'd63, 4'd15, '1);
      settle();

      write_init_bytes(8'h00, 8'h00, 8'h00);
      random_requests(20);
      write_init_bytes(8'hFF, 8'hFF, 8'hFF);
      random_requests(20);
      write_init_bytes(8'($urandom), 8'($urandom), 8'($urandom));
      random_requests(35);

      $display("requests: %0d command, %0d char, %0d number, %0d position, %0d pattern, %0d init, %0d unused",
               sent_by_kind[REQ_COMMAND], sent_by_kind[REQ_CHAR], sent_by_kind[REQ_NUMBER],
               sent_by_kind[REQ_SET_POS], sent_by_kind[REQ_PATTERN], sent_by_kind[REQ_INIT],
               sent_by_kind[REQ_UNUSED_LO] + sent_by_kind[REQ_UNUSED_HI]);
      $display("bus writes checked: %0d over %0d init command settings",
               beats_seen, settings_used);
      if (fail_count == 0 && writes_outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/clfmt_pkg.sv
hdl/clfmt_front.sv
hdl/clfmt_queue.sv
hdl/clfmt_back.sv
hdl/char_lcd_request_formatter_core.sv
bench/char_lcd_request_formatter_write_monitor.sv
bench/char_lcd_request_formatter_core_tb.sv
